// ===== src/adsr_envelope_stepper_top_assert.svh =====
// ----------------------------------------------------------------------------
// ADSR envelope stepper assertion macros
// Shared forms for the concurrent checks on the envelope stepper.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_STEPPER_TOP_ASSERT_SVH
`define ADSR_ENVELOPE_STEPPER_TOP_ASSERT_SVH

// Check that is suspended while reset is asserted.
`define ADSR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds across reset.
`define ADSR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope stepper package
// Shared constants, phase codes, register indexes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  localparam int TICKS_PER_UNIT = 52150;

  localparam int TIME_W  = 8;
  localparam int LIM_W   = 24;
  localparam int LEVEL_W = 14;
  localparam int AMP_W   = 16;
  localparam int PHASE_W = 2;
  localparam int SUB_W   = 2;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 14;

  localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DECAY   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SUSTAIN = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

  localparam logic [IDX_W-1:0] CFG_ATTACK_TIME   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_DECAY_TIME    = 3'd1;
  localparam logic [IDX_W-1:0] CFG_RELEASE_TIME  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [IDX_W-1:0] CFG_PEAK_LEVEL    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_SQUARE_MODE   = 3'd5;

  localparam logic [SUB_W-1:0] ATTACK_SUBS  = 2'd1;
  localparam logic [SUB_W-1:0] DECAY_SUBS   = 2'd2;
  localparam logic [SUB_W-1:0] RELEASE_SUBS = 2'd3;

  localparam logic [AMP_W-1:0] ATTACK_AMP_STEP  = 16'd2;
  localparam logic [AMP_W-1:0] DECAY_AMP_STEP   = 16'd4;
  localparam logic [AMP_W-1:0] RELEASE_AMP_STEP = 16'd2;

  typedef struct packed {
    logic [LIM_W-1:0]   lim_attack;
    logic [LIM_W-1:0]   lim_decay;
    logic [LIM_W-1:0]   lim_release;
    logic [LEVEL_W-1:0] sustain_level;
    logic [LEVEL_W-1:0] peak_level;
    logic               square_mode;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [SUB_W-1:0]   sub_step;
    logic [LIM_W-1:0]   tick_count;
    logic [LEVEL_W-1:0] level;
    logic [AMP_W-1:0]   amp;
  } state_t;

  typedef struct packed {
    logic [AMP_W-1:0]   amplitude;
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0] phase;
  } res_t;

endpackage

`default_nettype wire

// ===== src/adsr_cfg.sv =====
// ----------------------------------------------------------------------------
// ADSR configuration registers
// Holds the settings and turns each phase time into a tick limit on write.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [adsr_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [adsr_pkg::DATA_W-1:0] cfg_wdata,
  output adsr_pkg::cfg_t                 cfg
);
  import adsr_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [LIM_W-1:0] lim_wr;

  assign lim_wr = LIM_W'(cfg_wdata[TIME_W-1:0]) * LIM_W'(TICKS_PER_UNIT);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACK_TIME:   cfg_nxt.lim_attack    = lim_wr;
        CFG_DECAY_TIME:    cfg_nxt.lim_decay     = lim_wr;
        CFG_RELEASE_TIME:  cfg_nxt.lim_release   = lim_wr;
        CFG_SUSTAIN_LEVEL: cfg_nxt.sustain_level = cfg_wdata[LEVEL_W-1:0];
        CFG_PEAK_LEVEL:    cfg_nxt.peak_level    = cfg_wdata[LEVEL_W-1:0];
        CFG_SQUARE_MODE:   cfg_nxt.square_mode   = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lim_attack    <= LIM_W'(TICKS_PER_UNIT);
      cfg_r.lim_decay     <= LIM_W'(TICKS_PER_UNIT);
      cfg_r.lim_release   <= LIM_W'(TICKS_PER_UNIT);
      cfg_r.sustain_level <= 14'd8192;
      cfg_r.peak_level    <= 14'd16383;
      cfg_r.square_mode   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/adsr_step.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope step logic
// Next envelope state for one sample tick.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_step (
  input  wire adsr_pkg::state_t st,
  input  wire adsr_pkg::cfg_t   cfg,
  input  wire logic             rel_req,
  output adsr_pkg::state_t      st_nxt
);
  import adsr_pkg::*;

  logic             run_attack;
  logic             run_decay;
  logic             run_release;
  logic [SUB_W-1:0] sub_inc;
  logic [LIM_W-1:0] tick_inc;
  state_t           ns;

  assign run_attack  = st.tick_count < cfg.lim_attack;
  assign run_decay   = st.tick_count < cfg.lim_decay;
  assign run_release = st.tick_count < cfg.lim_release;
  assign sub_inc     = st.sub_step + SUB_W'(1);
  assign tick_inc    = st.tick_count + LIM_W'(1);

  always_comb begin
    ns = st;
    case (st.phase)
      PH_ATTACK: begin
        if (st.sub_step < ATTACK_SUBS && run_attack) begin
          ns.sub_step   = sub_inc;
          ns.tick_count = tick_inc;
          ns.amp        = st.amp - ATTACK_AMP_STEP;
        end else if (st.level < cfg.peak_level && run_attack) begin
          ns.sub_step   = '0;
          ns.tick_count = tick_inc;
          ns.level      = st.level + LEVEL_W'(1);
        end else begin
          ns.sub_step   = '0;
          ns.tick_count = '0;
          ns.amp        = AMP_W'(cfg.peak_level);
          ns.level      = cfg.peak_level;
          ns.phase      = PH_DECAY;
        end
      end
      PH_DECAY: begin
        if (st.sub_step < DECAY_SUBS && run_decay) begin
          ns.sub_step   = sub_inc;
          ns.tick_count = tick_inc;
          ns.amp        = st.amp + DECAY_AMP_STEP;
        end else if (run_decay && st.level > cfg.sustain_level) begin
          ns.sub_step   = '0;
          ns.tick_count = tick_inc;
          ns.level      = st.level - LEVEL_W'(1);
        end else begin
          ns.sub_step   = '0;
          ns.tick_count = '0;
          ns.amp        = AMP_W'(cfg.sustain_level);
          ns.level      = cfg.sustain_level;
          ns.phase      = PH_SUSTAIN;
        end
      end
      PH_SUSTAIN: begin
        if (rel_req) begin
          ns.phase = PH_RELEASE;
        end
      end
      default: begin
        if (st.sub_step < RELEASE_SUBS && run_release) begin
          ns.sub_step   = sub_inc;
          ns.tick_count = tick_inc;
          ns.amp        = st.amp + RELEASE_AMP_STEP;
        end else if (run_release && st.level != '0) begin
          ns.sub_step   = '0;
          ns.tick_count = tick_inc;
          ns.level      = st.level - LEVEL_W'(1);
        end else begin
          ns.sub_step   = '0;
          ns.tick_count = '0;
          ns.level      = '0;
          ns.amp        = '0;
          ns.phase      = PH_ATTACK;
        end
      end
    endcase
    if (cfg.square_mode) begin
      ns.amp = AMP_W'(ns.level);
    end
  end

  assign st_nxt = ns;

endmodule

`default_nettype wire

// ===== src/adsr_skid.sv =====
// ----------------------------------------------------------------------------
// ADSR result skid buffer
// Output register with one spare slot so a new word lands while one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_skid (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire adsr_pkg::res_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output adsr_pkg::res_t      out_data
);
  import adsr_pkg::*;

  logic main_valid_r;
  logic skid_valid_r;
  res_t main_data_r;
  res_t skid_data_r;
  logic pop;

  assign pop = main_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        main_data_r <= skid_data_r;
      end else if (push) begin
        main_data_r <= push_data;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_data_r <= push_data;
      end else begin
        main_data_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

`default_nettype wire

// ===== src/adsr_envelope_stepper_top.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope stepper top level
// One sample tick in, one envelope word out: amplitude, level and phase.
// ----------------------------------------------------------------------------
// Each word on the input channel is one sample tick carrying the release
// request bit. A word is taken at a clock edge where in_valid is high and
// in_stall is low. The envelope state advances on that same edge and the
// resulting word is registered into the output buffer on that same edge.
// A new tick is taken in every cycle while in_stall is low; the sustained rate
// is one word per cycle while the receiver does not stall, set by the
// combinational state update between the state register and output register.
// When the receiver stalls, the output word holds and one more tick is still
// taken into a spare slot; in_stall rises only when that slot is full.
// The configuration port writes one setting per cycle with cfg_we high; the
// phase time limits are computed at write time. The user must write settings
// only while no word is in flight; the block itself does not enforce it.
// A synchronous active-low reset returns the envelope to attack with level,
// amplitude and counters at zero, restores the default settings and empties
// the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_stepper_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_release_request,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [adsr_pkg::AMP_W-1:0]         out_amplitude,
  output logic [adsr_pkg::LEVEL_W-1:0]       out_level,
  output logic [adsr_pkg::PHASE_W-1:0]       out_phase,
  input  wire logic                          cfg_we,
  input  wire logic [adsr_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [adsr_pkg::DATA_W-1:0]   cfg_wdata
);
  import adsr_pkg::*;

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;
  res_t   res;
  res_t   out_data;
  logic   push;
  logic   full;

  adsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  adsr_step u_step (
    .st      (state_r),
    .cfg     (cfg),
    .rel_req (in_release_request),
    .st_nxt  (state_nxt)
  );

  assign push = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (push) begin
      state_r <= state_nxt;
    end
  end

  assign res.amplitude = state_nxt.amp;
  assign res.level     = state_nxt.level;
  assign res.phase     = state_nxt.phase;

  adsr_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall      = full;
  assign out_amplitude = out_data.amplitude;
  assign out_level     = out_data.level;
  assign out_phase     = out_data.phase;

endmodule

`default_nettype wire

// ===== src/adsr_checker.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope stepper checker
// Port-level checks on reset and on the output buffering, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adsr_envelope_stepper_top_assert.svh"

module adsr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall
);

  `ADSR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall, "output not empty after reset")
  `ADSR_ASSERT(a_stall_needs_word, clk, rst_n, in_stall |-> out_valid, "input stalled with no word pending")
  `ADSR_ASSERT(a_accept_gives_word, clk, rst_n, in_valid && !in_stall |=> out_valid, "accepted tick produced no word")
  `ADSR_ASSERT(a_spare_fills, clk, rst_n, in_valid && !in_stall && out_valid && out_stall |=> in_stall, "spare slot not filled while output stalled")

endmodule

bind adsr_envelope_stepper_top adsr_checker u_adsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire
